// ===== hw/rtl/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared widths, codes and defaults for the ballot path unranker.
// ----------------------------------------------------------------------------
package bpu_pkg;

  // default for the largest symbol count covered by the count table
  localparam int MAX_SYMBOLS_DEF = 28;

  localparam int SUPPORT_W = 32;
  localparam int LENGTH_W  = 6;
  localparam int OCC_W     = 5;
  localparam int RANK_W    = 64;
  localparam int WORD_W    = 64;

  localparam int POS_IDX_W = $clog2(SUPPORT_W);
  localparam int HEIGHT_W  = 6;   // height reaches at most SUPPORT_W + 1
  localparam int SEEN_W    = 6;   // up to SUPPORT_W set bits

  typedef logic [1:0] code_t;

  localparam code_t CODE_EMPTY = 2'd0;
  localparam code_t CODE_R     = 2'd1;
  localparam code_t CODE_L     = 2'd2;

endpackage

// ===== hw/rtl/bpu_ram.sv =====
// ----------------------------------------------------------------------------
// bpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpu_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bpu_fill.sv =====
// ----------------------------------------------------------------------------
// bpu_fill
// Builds the ballot count table after reset, one entry per cycle, row by row.
// ----------------------------------------------------------------------------
module bpu_fill #(
  parameter int MAX_SYMBOLS = bpu_pkg::MAX_SYMBOLS_DEF,
  parameter int CNT_W       = MAX_SYMBOLS,
  parameter int ADDR_W      = $clog2((MAX_SYMBOLS + 1) * (MAX_SYMBOLS + 2))
) (
  input  logic              clk,
  input  logic              rst,
  output logic              we,
  output logic [ADDR_W-1:0] waddr,
  output logic [CNT_W-1:0]  wdata,
  output logic              done
);

  localparam int ROWS  = MAX_SYMBOLS + 1;
  localparam int COLS  = MAX_SYMBOLS + 2;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);

  // previous row circulates through a shift line; new entries enter at the tail
  logic [CNT_W-1:0] row_sr [COLS];
  logic [CNT_W-1:0] last;     // previous-row entry one column to the left
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [CNT_W-1:0] entry;
  logic             last_col;
  logic             last_row;

  assign last_col = (col == COL_W'(COLS - 1));
  assign last_row = (row == ROW_W'(ROWS - 1));

  always_comb begin
    if (row == '0) begin
      entry = row_sr[0];
    end else if (last_col) begin
      entry = '0;
    end else begin
      entry = last + row_sr[1];
    end
  end

  assign we    = !done;
  assign wdata = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      row   <= '0;
      col   <= '0;
      waddr <= '0;
      last  <= '0;
      for (int i = 0; i < COLS; i++) begin
        row_sr[i] <= (i == 0) ? CNT_W'(1) : '0;
      end
    end else if (!done) begin
      for (int i = 0; i < COLS - 1; i++) begin
        row_sr[i] <= row_sr[i + 1];
      end
      row_sr[COLS - 1] <= entry;
      waddr <= waddr + ADDR_W'(1);
      if (last_col) begin
        col  <= '0;
        last <= '0;
        row  <= row + ROW_W'(1);
        if (last_row) begin
          done <= 1'b1;
        end
      end else begin
        col  <= col + COL_W'(1);
        last <= row_sr[0];
      end
    end
  end

endmodule

// ===== hw/rtl/bpu_walk.sv =====
// ----------------------------------------------------------------------------
// bpu_walk
// Position scanner and shared compare/subtract unit that unranks the path.
// ----------------------------------------------------------------------------
module bpu_walk #(
  parameter int MAX_SYMBOLS = bpu_pkg::MAX_SYMBOLS_DEF,
  parameter int CNT_W       = MAX_SYMBOLS,
  parameter int ADDR_W      = $clog2((MAX_SYMBOLS + 1) * (MAX_SYMBOLS + 2))
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         table_ready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bpu_pkg::SUPPORT_W-1:0] support_mask,
  input  logic [bpu_pkg::LENGTH_W-1:0]  length,
  input  logic [bpu_pkg::OCC_W-1:0]     occupied_count,
  input  logic [bpu_pkg::RANK_W-1:0]    path_rank,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bpu_pkg::WORD_W-1:0]    mate_word,
  output logic                         count_error,
  output logic                         rd_en,
  output logic [ADDR_W-1:0]            rd_addr,
  input  logic [CNT_W-1:0]             rd_data
);
  import bpu_pkg::*;

  localparam int COLS   = MAX_SYMBOLS + 2;
  localparam int WIDE_W = ADDR_W + 6;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t               state;
  logic [SUPPORT_W-1:0] support;
  logic [LENGTH_W-1:0]  len;
  logic [OCC_W-1:0]     occ;
  logic [RANK_W-1:0]    rank;
  logic [WORD_W-1:0]    word;
  logic [LENGTH_W-1:0]  pos;
  logic [SEEN_W-1:0]    seen;
  logic [HEIGHT_W-1:0]  height;
  logic                 err;
  logic                 zero_q;

  logic [SEEN_W-1:0]    seen_inc;
  logic [OCC_W-1:0]     rem;
  logic [HEIGHT_W-1:0]  col;
  logic                 lookup_zero;
  logic [WIDE_W-1:0]    addr_wide;
  logic                 bit_set;
  logic                 at_end;
  logic [RANK_W-1:0]    r_count;
  logic                 take_r;

  assign in_ready = table_ready && (state == S_IDLE);

  assign seen_inc  = seen + SEEN_W'(1);
  assign rem       = occ - seen_inc[OCC_W-1:0];
  assign col       = height - HEIGHT_W'(1);
  assign at_end    = (pos == len);
  assign bit_set   = support[pos[POS_IDX_W-1:0]] && !err;

  // entries outside the table, and height zero, count as no R paths
  assign lookup_zero = (height == '0) ||
                       ({1'b0, rem} > SEEN_W'(MAX_SYMBOLS)) ||
                       (col >= HEIGHT_W'(COLS));
  assign addr_wide = WIDE_W'(rem) * WIDE_W'(COLS) + WIDE_W'(col);
  assign rd_addr   = addr_wide[ADDR_W-1:0];
  assign rd_en     = (state == S_SCAN) && !at_end && bit_set && (seen_inc <= SEEN_W'(occ));

  assign r_count = zero_q ? '0 : RANK_W'(rd_data);
  assign take_r  = (rank < r_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result loaded in S_DONE takes over the slot instead
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            support <= support_mask;
            len     <= (length > LENGTH_W'(SUPPORT_W)) ? LENGTH_W'(SUPPORT_W) : length;
            occ     <= occupied_count;
            rank    <= path_rank;
            word    <= '0;
            pos     <= '0;
            seen    <= '0;
            height  <= HEIGHT_W'(1);
            err     <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (at_end) begin
            state <= S_DONE;
          end else if (rd_en) begin
            seen   <= seen_inc;
            zero_q <= lookup_zero;
            state  <= S_DECIDE;
          end else begin
            // empty position, or a set bit past the occupied count
            if (bit_set) begin
              err <= 1'b1;
            end
            word <= {word[WORD_W-3:0], CODE_EMPTY};
            pos  <= pos + LENGTH_W'(1);
          end
        end
        S_DECIDE: begin
          if (take_r) begin
            word   <= {word[WORD_W-3:0], CODE_R};
            height <= height - HEIGHT_W'(1);
          end else begin
            word   <= {word[WORD_W-3:0], CODE_L};
            height <= height + HEIGHT_W'(1);
            rank   <= rank - r_count;
          end
          pos   <= pos + LENGTH_W'(1);
          state <= S_SCAN;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            mate_word   <= word;
            count_error <= err;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ballot_path_unrank_to_mate_word_top.sv =====
// ----------------------------------------------------------------------------
// ballot_path_unrank_to_mate_word_top
// Unranks a ballot path over a support mask into a two-bit-per-position word.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | support_mask, length, occupied_count, path_rank
//  out     | out_valid / out_ready | mate_word, count_error
//
//  From accept the block scans one position at a time up to min(length,32);
//  each set bit walked adds a table read and the shared compare/subtract,
//  and the end of scan and the result load follow. One transaction at a time:
//  the next accept can follow once the result is loaded.
//  After reset the count table is built, one entry per cycle:
//  (MAX_SYMBOLS+1)*(MAX_SYMBOLS+2) entries (870 at the default), in_ready low.
//  A result waiting on out_ready stalls only the result load of the next item.
// ----------------------------------------------------------------------------
module ballot_path_unrank_to_mate_word_top #(
  parameter int MAX_SYMBOLS = bpu_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpu_pkg::SUPPORT_W-1:0] support_mask,
  input  logic [bpu_pkg::LENGTH_W-1:0]  length,
  input  logic [bpu_pkg::OCC_W-1:0]     occupied_count,
  input  logic [bpu_pkg::RANK_W-1:0]    path_rank,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpu_pkg::WORD_W-1:0]    mate_word,
  output logic                          count_error
);
  import bpu_pkg::*;

  localparam int DEPTH  = (MAX_SYMBOLS + 1) * (MAX_SYMBOLS + 2);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = MAX_SYMBOLS;  // row r entries (r >= 1) stay below 2**r

  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;
  logic [CNT_W-1:0]  tbl_wdata;
  logic              tbl_done;
  logic              tbl_re;
  logic [ADDR_W-1:0] tbl_raddr;
  logic [CNT_W-1:0]  tbl_rdata;

  bpu_fill #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_fill (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .done  (tbl_done)
  );

  bpu_ram #(
    .WIDTH  (CNT_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  bpu_walk #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .CNT_W       (CNT_W),
    .ADDR_W      (ADDR_W)
  ) u_walk (
    .clk            (clk),
    .rst            (rst),
    .table_ready    (tbl_done),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .support_mask   (support_mask),
    .length         (length),
    .occupied_count (occupied_count),
    .path_rank      (path_rank),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mate_word      (mate_word),
    .count_error    (count_error),
    .rd_en          (tbl_re),
    .rd_addr        (tbl_raddr),
    .rd_data        (tbl_rdata)
  );

endmodule

// ===== hw/rtl/bpu_checker.sv =====
// ----------------------------------------------------------------------------
// bpu_checker
// Port-level checks for the ballot path unranker, bound to the top level.
// ----------------------------------------------------------------------------
module bpu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [bpu_pkg::SUPPORT_W-1:0] support_mask,
  input logic [bpu_pkg::LENGTH_W-1:0]  length,
  input logic [bpu_pkg::OCC_W-1:0]     occupied_count,
  input logic [bpu_pkg::RANK_W-1:0]    path_rank,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bpu_pkg::WORD_W-1:0]    mate_word,
  input logic                          count_error
);

  // table build keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("input open while count table is being built");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  // a result needs at least the scan and hand-off cycles
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared right after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(mate_word) &&
                                   $stable(count_error)))
    else $error("stalled result changed or dropped");

endmodule

bind ballot_path_unrank_to_mate_word_top bpu_checker u_bpu_checker (.*);

// ===== verif/tb_ballot_path_unrank_to_mate_word_top.sv =====
// ----------------------------------------------------------------------------
// tb_ballot_path_unrank_to_mate_word_top
// Self-checking bench for the ballot path unranker. A directed table covers
// the field extremes and the corner cases: empty length, truncation on too
// many set bits, heights and counts off the edge of the count table, and
// oversized ranks. A long random run follows, mostly well-formed paths with
// in-range ranks. Results are checked against a local unranking model, or for
// the typed directed rows against written-out values, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_ballot_path_unrank_to_mate_word_top;

  import bpu_pkg::*;

  localparam int MAX_SYM        = MAX_SYMBOLS_DEF;
  localparam int RAND_ITEMS     = 1950;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT_ITEM   = 300;
  localparam int PAUSE_AT_ITEM  = 1000;

  typedef struct packed {
    logic [SUPPORT_W-1:0] support;
    logic [LENGTH_W-1:0]  len;
    logic [OCC_W-1:0]     occ;
    logic [RANK_W-1:0]    rank;
  } unrank_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] mate;
    logic              cnt_err;
  } mate_result_t;

  typedef struct packed {
    unrank_req_t  req;
    logic         typed;   // result written out below, not predicted
    mate_result_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [SUPPORT_W-1:0] support_mask;
  logic [LENGTH_W-1:0]  length;
  logic [OCC_W-1:0]     occupied_count;
  logic [RANK_W-1:0]    path_rank;
  logic out_valid;
  logic out_ready;
  logic [WORD_W-1:0] mate_word;
  logic count_error;

  logic [63:0] ballot_cnt [0:MAX_SYM][0:MAX_SYM+1];
  mate_result_t pending_words [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_rx = 1'b0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // length zero: nothing in use
    '{'{32'hFFFF_FFFF, 6'd0, 5'd5, 64'hDEAD_BEEF_0123_4567}, 1'b1, '{64'h0, 1'b0}},
    '{'{32'h0000_0000, 6'd32, 5'd0, 64'h0}, 1'b1, '{64'h0, 1'b0}},
    '{'{32'h0000_0001, 6'd1, 5'd1, 64'h0}, 1'b1, '{64'h1, 1'b0}},
    '{'{32'h0000_0001, 6'd1, 5'd1, 64'h1}, 1'b1, '{64'h2, 1'b0}},
    // second set bit overruns the count: R kept, rest empty
    '{'{32'h0000_0003, 6'd2, 5'd1, 64'h0}, 1'b1, '{64'h4, 1'b1}},
    '{'{32'h0000_0001, 6'd1, 5'd0, 64'h0}, 1'b1, '{64'h0, 1'b1}},
    '{'{32'hFFFF_FFFF, 6'd32, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{64'h0, 1'b1}},
    '{'{32'h0000_0000, 6'd63, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{64'h0, 1'b0}},
    '{'{32'h8000_0000, 6'd32, 5'd1, 64'h0}, 1'b1, '{64'h1, 1'b0}},
    // top bit lies beyond length
    '{'{32'h8000_0000, 6'd31, 5'd1, 64'h0}, 1'b1, '{64'h0, 1'b0}},
    '{'{32'hFFFF_FFFF, 6'd32, 5'd28, 64'h0}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'hFFFF_FFFF, 6'd32, 5'd28, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '{64'h0, 1'b0}},
    // climbs past the table height, then truncates
    '{'{32'hFFFF_FFFF, 6'd32, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'h7FFF_FFFF, 6'd32, 5'd31, 64'h0}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'hFFFF_FFFF, 6'd33, 5'd27, 64'd1234567}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'hFFFF_FFFF, 6'd63, 5'd31, 64'h0}, 1'b0, '{64'h0, 1'b0}},
    // R drops to height zero, next symbol forced to L
    '{'{32'h0000_0003, 6'd2, 5'd3, 64'h0}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'h0000_0007, 6'd3, 5'd3, 64'h0}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'h0000_0007, 6'd3, 5'd3, 64'h1}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'h5555_5555, 6'd32, 5'd16, 64'h0000_0000_0000_FFFF}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'hAAAA_AAAA, 6'd32, 5'd16, 64'h0000_0000_FFFF_0000}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'h0FFF_FFFF, 6'd28, 5'd27, 64'd2674439}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'hF000_000F, 6'd32, 5'd7, 64'd100}, 1'b0, '{64'h0, 1'b0}},
    '{'{32'h0000_0001, 6'd32, 5'd31, 64'h0}, 1'b0, '{64'h0, 1'b0}}
  };

  ballot_path_unrank_to_mate_word_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .support_mask   (support_mask),
    .length         (length),
    .occupied_count (occupied_count),
    .path_rank      (path_rank),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mate_word      (mate_word),
    .count_error    (count_error)
  );

  always #1 clk = ~clk;

  // [rem][h]: paths of rem steps from height h that end at zero, never below
  initial begin : build_ballot_table
    for (int r = 0; r <= MAX_SYM; r++) begin
      for (int c = 0; c <= MAX_SYM + 1; c++) begin
        ballot_cnt[r][c] = '0;
      end
    end
    ballot_cnt[0][0] = 64'd1;
    for (int r = 1; r <= MAX_SYM; r++) begin
      for (int c = 0; c <= MAX_SYM; c++) begin
        ballot_cnt[r][c] = ballot_cnt[r-1][c+1] + ((c > 0) ? ballot_cnt[r-1][c-1] : 64'd0);
      end
    end
  end

  function automatic logic [63:0] ballot_lookup(int rem, int col);
    if (rem > MAX_SYM || col > MAX_SYM + 1) begin
      return '0;
    end
    return ballot_cnt[rem][col];
  endfunction

  function automatic mate_result_t unrank_path(unrank_req_t req);
    mate_result_t res;
    int len;
    int height;
    int seen;
    int rem;
    logic [63:0] rank;
    logic [63:0] r_count;
    code_t code;
    res.mate    = '0;
    res.cnt_err = 1'b0;
    len    = (req.len > 6'd32) ? 32 : int'(req.len);
    height = 1;
    seen   = 0;
    rank   = req.rank;
    for (int pos = 0; pos < len; pos++) begin
      if (req.support[pos] && !res.cnt_err) begin
        seen++;
        if (seen > int'(req.occ)) begin
          res.cnt_err = 1'b1;
        end else begin
          rem     = int'(req.occ) - seen;
          r_count = (height > 0) ? ballot_lookup(rem, height - 1) : 64'd0;
          if (rank < r_count) begin
            code = CODE_R;
            height--;
          end else begin
            rank -= r_count;
            code = CODE_L;
            height++;
          end
          res.mate |= 64'(code) << (2 * (len - 1 - pos));
        end
      end
    end
    return res;
  endfunction

  // mostly short, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic unrank_req_t random_request();
    unrank_req_t req;
    int kind;
    int k;
    int len;
    logic [63:0] total;
    kind     = $urandom_range(0, 99);
    req.rank = {$urandom, $urandom};
    if (kind < 12) begin
      req.support = $urandom;
      req.len     = LENGTH_W'($urandom);
      req.occ     = OCC_W'($urandom);
      return req;
    end
    if (kind < 72) k = 2 * $urandom_range(0, (MAX_SYM - 1) / 2) + 1;
    else if (kind < 86) k = $urandom_range(1, MAX_SYM);
    else k = $urandom_range(0, MAX_SYM);
    len         = $urandom_range((k > 0) ? k : 1, 32);
    req.len     = LENGTH_W'(len);
    req.support = '0;
    while ($countones(req.support) < k) begin
      req.support[$urandom_range(0, len - 1)] = 1'b1;
    end
    req.occ = OCC_W'(k);
    if (kind < 72) begin
      // well-formed: rank within the path count
      total = ballot_lookup(k, 1);
      if (total != 0) req.rank = req.rank % total;
    end else if (kind < 86) begin
      req.occ = OCC_W'($urandom_range(0, k - 1));
    end else begin
      req.occ = OCC_W'($urandom_range(k, 31));
      if (len < 32) req.support |= $urandom & ~((32'd1 << len) - 32'd1);
    end
    return req;
  endfunction

  task automatic send_request(unrank_req_t req, logic typed, mate_result_t want, bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    support_mask   <= req.support;
    length         <= req.len;
    occupied_count <= req.occ;
    path_rank      <= req.rank;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_words.push_back(typed ? want : unrank_path(req));
  endtask

  initial begin : tx_side
    unrank_req_t req;
    rst            = 1'b1;
    in_valid       = 1'b0;
    support_mask   = '0;
    length         = '0;
    occupied_count = '0;
    path_rank      = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want, 1'b0);
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == HOLD_AT_ITEM) hold_rx = 1'b1;
      if (i == PAUSE_AT_ITEM) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
      end
      req = random_request();
      send_request(req, 1'b0, '0, (i % 200) < 25);
    end
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("ballot_path_unrank_to_mate_word_top regression: pass");
    end else begin
      $display("ballot_path_unrank_to_mate_word_top regression: fail");
    end
    $finish;
  end

  initial begin : rx_side
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        // long hold-off so the block backs up into its input
        hold_rx = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, ($urandom_range(0, 19) == 0) ? 150 : 6)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    mate_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected transaction: mate_word %h count_error %b", mate_word, count_error);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (mate_word !== want.mate) begin
          $error("mate_word: expected %h, got %h", want.mate, mate_word);
          mismatches++;
        end
        if (count_error !== want.cnt_err) begin
          $error("count_error: expected %b, got %b", want.cnt_err, count_error);
          mismatches++;
        end
      end
    end
  end

  // table build after reset keeps in_ready low; limit covers it
  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("ballot_path_unrank_to_mate_word_top regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
